[sv/stereo_feedback_echo_macros.svh]
// Assertion macros shared by the echo block's RTL files.
`ifndef STEREO_FEEDBACK_ECHO_MACROS_SVH
`define STEREO_FEEDBACK_ECHO_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, disabled in reset
`define SFE_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfe: assertion failed");
// next-cycle implication, disabled in reset
`define SFE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfe: assertion failed");
`else
`define SFE_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define SFE_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

[sv/sfe_pkg.sv]
// Package: constants, types and arithmetic helpers of the stereo echo block.
`timescale 1ns / 1ps
package sfe_pkg;

    // store geometry and sample format
    localparam int STORE_DEPTH = 131072;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // register field widths
    localparam int DELAY_W   = 17;
    localparam int FB_W      = 16;
    localparam int GAIN_W    = 17;
    localparam int FRAC_BITS = 16;

    // arithmetic widths
    localparam int PROD_W = SAMPLE_BITS + GAIN_W + 1;
    localparam int SUM_W  = 2 * SAMPLE_BITS;

    // gain constants: feedback and slope Q0.16, unity gain Q1.16
    localparam logic [FB_W-1:0]    FB_MAX    = FB_W'(60293);
    localparam logic [GAIN_W-1:0]  GAIN_ONE  = GAIN_W'(65536);
    localparam logic [14:0]        DRY_SLOPE = 15'd29491;
    localparam logic [DELAY_W-1:0] DELAY_MAX = DELAY_W'(STORE_DEPTH - 1);

    // reset values
    localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(15360);
    localparam logic [FB_W-1:0]    FB_RESET    = FB_W'(18350);
    localparam logic [GAIN_W-1:0]  WET_RESET   = GAIN_W'(14418);
    localparam logic [GAIN_W-1:0]  DRY_RESET   =
        GAIN_W'(65536 - ((14418 * 29491 + 32768) / 65536));

    // APB register map
    localparam int NUM_REGS = 5;
    localparam int PADDR_W  = $clog2(NUM_REGS * 4);
    localparam int PDATA_W  = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE   = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_DELAY    = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_FEEDBACK = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_WET      = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_STEREO   = REG_IDX_W'(4);

    // rounding and saturation limits
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);
    localparam logic signed [SUM_W-1:0]  SAT_HI = SUM_W'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [SUM_W-1:0]  SAT_LO = SUM_W'(-(2 ** (SAMPLE_BITS - 1)));

    // effective settings seen by the datapath
    typedef struct packed {
        logic              enable;
        logic              stereo;
        logic [ADDR_W-1:0] delay;
        logic [FB_W-1:0]   fb;
        logic [GAIN_W-1:0] wet;
        logic [GAIN_W-1:0] dry;
    } t_cfg;

    // per-lane pipeline control from the top level
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic [ADDR_W-1:0] wr_addr;
        logic              proc;
        logic              s1_adv;
        logic              s2_adv;
        logic              clearing;
        logic [ADDR_W-1:0] clr_addr;
    } t_lane_ctl;

    // floor(x / 65536 + 0.5)
    function automatic logic signed [PROD_W-1:0] round_q16(input logic signed [PROD_W-1:0] x);
        return (x + ROUND_HALF) >>> FRAC_BITS;
    endfunction

    // clamp to the sample range
    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [SUM_W-1:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[SAMPLE_BITS-1:0];
    endfunction

endpackage

[sv/sfe_if.sv]
// Stream interfaces: input frame and output frame channels.
`timescale 1ns / 1ps
interface sfe_in_if import sfe_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;

    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sfe_out_if import sfe_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

[sv/stereo_feedback_echo.sv]
// Top level of the stereo feedback echo: frame pipeline control and two channel lanes.
`timescale 1ns / 1ps
`include "stereo_feedback_echo_macros.svh"
// Stereo feedback echo. Takes one frame per clock cycle while the output side is
// ready and no clearing pass runs, and returns one result frame per input frame,
// in order; the result passes through stage 1, stage 2 and the output register.
// Each channel keeps its own 131072-entry store in a single-port-write RAM;
// every frame does one read per store, and one write where its lane processes;
// back-to-back frames that touch the same entry (delay of one or two frames) are
// served by forwarding from the write-back stage and the last committed write.
// After reset a clearing pass zeroes both stores, one entry per cycle, so no
// frame is accepted until the pass is done; register writes are taken throughout.
// Settings are applied as written (delay clamped to 1..depth-1, feedback to 0.92,
// wet to 1.0) and must only change while no frame is in flight.
module stereo_feedback_echo import sfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sfe_in_if.sink             i_in,
    sfe_out_if.source          o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    t_cfg                          cfg;
    t_lane_ctl                     ctl_l;
    t_lane_ctl                     ctl_r;
    logic                          r_s1_valid;
    logic                          r_s2_valid;
    logic                          r_out_valid;
    logic [ADDR_W-1:0]             r_wp;
    logic                          r_clearing;
    logic [ADDR_W-1:0]             r_clr_addr;
    logic                          in_acc;
    logic                          out_acc;
    logic                          s1_adv;
    logic                          s2_adv;
    logic [ADDR_W-1:0]             rd_addr;
    logic signed [SAMPLE_BITS-1:0] left_res;
    logic signed [SAMPLE_BITS-1:0] right_res;

    sfe_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // stage advance: each stage moves when the next is free or moving
    assign out_acc    = r_out_valid & o_out.ready;
    assign s2_adv     = r_s2_valid & (~r_out_valid | o_out.ready);
    assign s1_adv     = r_s1_valid & (~r_s2_valid | s2_adv);
    assign i_in.ready = ~r_clearing & (~r_s1_valid | s1_adv);
    assign in_acc     = i_in.valid & i_in.ready;

    // read the entry written delay frames ago
    assign rd_addr = r_wp - cfg.delay;

    // lane control
    always_comb begin
        ctl_l.rd_en    = in_acc;
        ctl_l.rd_addr  = rd_addr;
        ctl_l.wr_addr  = r_wp;
        ctl_l.proc     = cfg.enable;
        ctl_l.s1_adv   = s1_adv;
        ctl_l.s2_adv   = s2_adv;
        ctl_l.clearing = r_clearing;
        ctl_l.clr_addr = r_clr_addr;
        ctl_r          = ctl_l;
        ctl_r.proc     = cfg.enable & cfg.stereo;
    end

    sfe_lane u_lane_l (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_l),
        .i_cfg    (cfg),
        .i_sample (i_in.left_sample),
        .o_sample (left_res)
    );

    sfe_lane u_lane_r (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_r),
        .i_cfg    (cfg),
        .i_sample (i_in.right_sample),
        .o_sample (right_res)
    );

    // stage valids, write position and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wp        <= '0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            r_s1_valid  <= in_acc | (r_s1_valid & ~s1_adv);
            r_s2_valid  <= s1_adv | (r_s2_valid & ~s2_adv);
            r_out_valid <= s2_adv | (r_out_valid & ~out_acc);
            if (in_acc && cfg.enable) begin
                r_wp <= r_wp + ADDR_W'(1);
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
        end
    end

    // result channel; right is silent in mono
    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = left_res;
    assign o_out.right_out = cfg.stereo ? right_res : '0;

    `SFE_ASSERT_NEXT(a_wp_step, i_clk, i_rst_n, in_acc && cfg.enable, r_wp == $past(r_wp) + ADDR_W'(1))
    `SFE_ASSERT_NEXT(a_s2_keep, i_clk, i_rst_n, r_s2_valid && !s2_adv, r_s2_valid)
    `SFE_ASSERT_IMPL(a_clear_end, i_clk, i_rst_n, $fell(r_clearing), r_clr_addr == '0)

endmodule

[sv/sfe_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
module sfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sfe_cfg.sv]
// APB register file: raw settings for readback and clamped values for the datapath.
`timescale 1ns / 1ps
module sfe_cfg import sfe_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    logic                 r_enable;
    logic                 r_stereo;
    logic [DELAY_W-1:0]   r_delay;
    logic [FB_W-1:0]      r_fb;
    logic [GAIN_W-1:0]    r_wet;
    logic [ADDR_W-1:0]    r_delay_eff;
    logic [FB_W-1:0]      r_fb_eff;
    logic [GAIN_W-1:0]    r_wet_eff;
    logic [GAIN_W-1:0]    r_dry;
    logic [GAIN_W-1:0]    n_dry;
    logic [31:0]          dry_prod;
    logic [DELAY_W-1:0]   wr_delay;
    logic [FB_W-1:0]      wr_fb;
    logic [GAIN_W-1:0]    wr_wet;
    logic [REG_IDX_W-1:0] idx;
    logic                 wr;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = paddr[PADDR_W-1:2];

    assign wr_delay = pwdata[DELAY_W-1:0];
    assign wr_fb    = pwdata[FB_W-1:0];
    assign wr_wet   = pwdata[GAIN_W-1:0];

    // dry gain = 1 - round(0.45 * wet)
    assign dry_prod = 32'(r_wet_eff) * 32'(DRY_SLOPE);
    assign n_dry    = GAIN_ONE - GAIN_W'((dry_prod + 32'd32768) >> FRAC_BITS);

    // register writes, clamped copies taken alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b1;
            r_stereo    <= 1'b1;
            r_delay     <= DELAY_RESET;
            r_fb        <= FB_RESET;
            r_wet       <= WET_RESET;
            r_delay_eff <= ADDR_W'(DELAY_RESET);
            r_fb_eff    <= FB_RESET;
            r_wet_eff   <= WET_RESET;
            r_dry       <= DRY_RESET;
        end else begin
            r_dry <= n_dry;
            if (wr) begin
                case (idx)
                    REG_ENABLE: begin
                        r_enable <= pwdata[0];
                    end
                    REG_DELAY: begin
                        r_delay <= wr_delay;
                        if (wr_delay == '0) begin
                            r_delay_eff <= ADDR_W'(1);
                        end else if (wr_delay > DELAY_MAX) begin
                            r_delay_eff <= ADDR_W'(DELAY_MAX);
                        end else begin
                            r_delay_eff <= ADDR_W'(wr_delay);
                        end
                    end
                    REG_FEEDBACK: begin
                        r_fb     <= wr_fb;
                        r_fb_eff <= (wr_fb > FB_MAX) ? FB_MAX : wr_fb;
                    end
                    REG_WET: begin
                        r_wet     <= wr_wet;
                        r_wet_eff <= (wr_wet > GAIN_ONE) ? GAIN_ONE : wr_wet;
                    end
                    REG_STEREO: begin
                        r_stereo <= pwdata[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // readback of raw values
    always_comb begin
        case (idx)
            REG_ENABLE:   prdata = PDATA_W'(r_enable);
            REG_DELAY:    prdata = PDATA_W'(r_delay);
            REG_FEEDBACK: prdata = PDATA_W'(r_fb);
            REG_WET:      prdata = PDATA_W'(r_wet);
            REG_STEREO:   prdata = PDATA_W'(r_stereo);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.enable = r_enable;
    assign o_cfg.stereo = r_stereo;
    assign o_cfg.delay  = r_delay_eff;
    assign o_cfg.fb     = r_fb_eff;
    assign o_cfg.wet    = r_wet_eff;
    assign o_cfg.dry    = r_dry;

endmodule

[sv/sfe_lane.sv]
// One channel: delay store, read-modify-write with forwarding, feedback and mix.
`timescale 1ns / 1ps
`include "stereo_feedback_echo_macros.svh"
module sfe_lane import sfe_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_lane_ctl                     i_ctl,
    input  t_cfg                          i_cfg,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);

    // stage 1: sample waiting on the store read
    logic signed [SAMPLE_BITS-1:0] r_s1_in;
    logic [ADDR_W-1:0]             r_s1_ra;
    logic [ADDR_W-1:0]             r_s1_wa;
    logic                          r_s1_proc;
    // stage 2: write-back value and mix products
    logic signed [SAMPLE_BITS-1:0] r_s2_in;
    logic signed [SAMPLE_BITS-1:0] r_s2_wd;
    logic [ADDR_W-1:0]             r_s2_wa;
    logic                          r_s2_proc;
    logic                          r_s2_wr;
    logic signed [PROD_W-1:0]      r_s2_pw;
    logic signed [PROD_W-1:0]      r_s2_pd;
    // last write committed to the store
    logic                          r_pv_v;
    logic [ADDR_W-1:0]             r_pv_a;
    logic signed [SAMPLE_BITS-1:0] r_pv_d;
    logic signed [SAMPLE_BITS-1:0] r_out;

    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [SAMPLE_BITS-1:0]        ram_wdata;
    logic                          s2_commit;
    logic signed [SAMPLE_BITS-1:0] delayed;
    logic signed [SAMPLE_BITS-1:0] n_wd;
    logic signed [SAMPLE_BITS-1:0] n_out;
    logic signed [PROD_W-1:0]      prod_fb;
    logic signed [PROD_W-1:0]      prod_wet;
    logic signed [PROD_W-1:0]      prod_dry;
    logic signed [PROD_W-1:0]      mix_sum;

    assign s2_commit = i_ctl.s2_adv & r_s2_wr;

    // store port: clearing pass after reset, else stage 2 write-back
    assign ram_we    = i_ctl.clearing | s2_commit;
    assign ram_waddr = i_ctl.clearing ? i_ctl.clr_addr : r_s2_wa;
    assign ram_wdata = i_ctl.clearing ? '0 : r_s2_wd;

    sfe_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_ctl.rd_addr),
        .o_rdata (ram_rdata)
    );

    // stage 1: forward pending writes, feedback and mix products
    always_comb begin
        if (r_s2_wr && (r_s2_wa == r_s1_ra)) begin
            delayed = r_s2_wd;
        end else if (r_pv_v && (r_pv_a == r_s1_ra)) begin
            delayed = r_pv_d;
        end else begin
            delayed = $signed(ram_rdata);
        end
        prod_fb  = PROD_W'(delayed) * PROD_W'($signed({1'b0, i_cfg.fb}));
        prod_wet = PROD_W'(delayed) * PROD_W'($signed({1'b0, i_cfg.wet}));
        prod_dry = PROD_W'(r_s1_in) * PROD_W'($signed({1'b0, i_cfg.dry}));
        n_wd     = sat_sample(SUM_W'(r_s1_in) + SUM_W'(round_q16(prod_fb)));
    end

    // stage 2: dry plus wet, or pass-through
    always_comb begin
        mix_sum = r_s2_pw + r_s2_pd;
        if (r_s2_proc) begin
            n_out = sat_sample(SUM_W'(round_q16(mix_sum)));
        end else begin
            n_out = r_s2_in;
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_s1_in <= i_sample;
            r_s1_ra <= i_ctl.rd_addr;
            r_s1_wa <= i_ctl.wr_addr;
        end
        if (i_ctl.s1_adv) begin
            r_s2_in   <= r_s1_in;
            r_s2_wd   <= n_wd;
            r_s2_wa   <= r_s1_wa;
            r_s2_pw   <= prod_wet;
            r_s2_pd   <= prod_dry;
            r_s2_proc <= r_s1_proc;
        end
        if (s2_commit) begin
            r_pv_a <= r_s2_wa;
            r_pv_d <= r_s2_wd;
        end
        if (i_ctl.s2_adv) begin
            r_out <= n_out;
        end
    end

    // write-pending and forwarding flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_proc <= 1'b0;
            r_s2_wr   <= 1'b0;
            r_pv_v    <= 1'b0;
        end else begin
            if (i_ctl.rd_en) begin
                r_s1_proc <= i_ctl.proc;
            end
            if (i_ctl.s1_adv) begin
                r_s2_wr <= r_s1_proc;
            end else if (i_ctl.s2_adv) begin
                r_s2_wr <= 1'b0;
            end
            if (i_ctl.clearing) begin
                r_pv_v <= 1'b0;
            end else if (s2_commit) begin
                r_pv_v <= 1'b1;
            end
        end
    end

    assign o_sample = r_out;

    // no echo write may collide with the clearing pass
    `SFE_ASSERT_IMPL(a_no_wr_in_clear, i_clk, i_rst_n, i_ctl.clearing, !s2_commit)

endmodule
